>>> design/assert_macros.svh
// Assertion shorthands for the checker file ca3d_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define CA3D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define CA3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CA3D_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ca3d_pkg.sv
`default_nettype none

package ca3d_pkg;

    // grid capacity
    localparam int MAX_X = 32;
    localparam int MAX_Y = 32;
    localparam int MAX_Z = 32;

    localparam int X_W    = $clog2(MAX_X);
    localparam int Y_W    = $clog2(MAX_Y);
    localparam int Z_W    = $clog2(MAX_Z);
    localparam int ROW_W  = X_W + Y_W;
    localparam int ADDR_W = ROW_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // field and register widths
    localparam int REQ_W     = 2;
    localparam int COORD_W   = 5;
    localparam int SIZE_W    = 6;
    localparam int RULE_W    = 5;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 6;
    localparam int OFS_W     = 2;

    function automatic int max_of(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // clamped extent width: holds the register value and every capacity
    localparam int EXT_W = max_of(SIZE_W, max_of($clog2(MAX_X + 1),
                                  max_of($clog2(MAX_Y + 1), $clog2(MAX_Z + 1))));

    // neighbor offsets run 0..2 and stand for -1..+1
    localparam logic [OFS_W-1:0] OFS_MID  = 2'd1;
    localparam logic [OFS_W-1:0] OFS_LAST = 2'd2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_LOW = 3'd5;

    // register reset values
    localparam logic [SIZE_W-1:0] SIZE_RST        = 6'd32;
    localparam logic [RULE_W-1:0] BIRTH_LOW_RST   = 5'd8;
    localparam logic [RULE_W-1:0] BIRTH_HIGH_RST  = 5'd10;
    localparam logic [RULE_W-1:0] SURVIVE_LOW_RST = 5'd5;

    typedef logic [MAX_Z-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_WAIT,
        S_GEN_RD,
        S_GEN_FIN,
        S_GEN_WR,
        S_RESP
    } t_state;

    // lane unit control
    typedef struct packed {
        logic clr;
        logic acc;
        logic center;
    } t_lane_ctl;

    // extent limited to the grid capacity
    function automatic logic [EXT_W-1:0] clamp_ext(input logic [SIZE_W-1:0] v, input int lim);
        logic [EXT_W-1:0] res;
        if (int'(v) > lim) begin
            res = EXT_W'(lim);
        end else begin
            res = EXT_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/cellular_automaton_3d_step_top.sv
`default_nettype none

// 3D life-like automaton over a MAX_X x MAX_Y x MAX_Z grid of one-bit cells
// with a 26-cell neighborhood and no wrap. Cells live in one single-port-read
// RAM as rows of MAX_Z bits along z, two banks, addressed {bank, x, y}. After
// reset the block clears every row of bank 0, one row a cycle, and takes no
// item meanwhile; configuration writes are taken at any time. A read or write
// item inside the used extent goes through row fetch, read-modify-write or bit
// pick, and result; an item refused for its coordinate and an item with the
// unused request code go through accept and result. A generation item walks
// all MAX_X*MAX_Y rows: the single RAM read port fetches the nine neighbor rows
// of a row one per cycle, a bank of MAX_Z lane counters accumulates them, and
// the new row goes to the other bank. The result step waits while the result
// channel still holds an earlier result that is not yet taken. One item is
// worked on at a time; the next is accepted while a result still waits.
module cellular_automaton_3d_step_top import ca3d_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [COORD_W-1:0]   i_cell_x,
    input  wire logic [COORD_W-1:0]   i_cell_y,
    input  wire logic [COORD_W-1:0]   i_cell_z,
    input  wire logic                 i_cell_value,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_read_value,
    output logic                      o_status
);

    // configuration registers
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [RULE_W-1:0] r_birth_low, r_birth_high, r_survive_low;

    // control state
    t_state           r_state, n_state;
    logic             r_sel, n_sel;
    logic [ROW_W-1:0] r_clr_cnt, n_clr_cnt;
    logic             r_pend_vld, n_pend_vld;
    logic             r_out_vld;

    // working registers
    logic [X_W-1:0]   r_gx, n_gx;
    logic [Y_W-1:0]   r_gy, n_gy;
    logic [OFS_W-1:0] r_dx, n_dx, r_dy, n_dy;
    logic             r_pend_use, n_pend_use;
    logic             r_pend_ctr, n_pend_ctr;
    logic [REQ_W-1:0] r_req, n_req;
    logic [X_W-1:0]   r_ax, n_ax;
    logic [Y_W-1:0]   r_ay, n_ay;
    logic [Z_W-1:0]   r_az, n_az;
    logic             r_aval, n_aval;
    logic             r_res_rd, n_res_rd;
    logic             r_res_st, n_res_st;
    logic             r_out_rd, r_out_st;

    // datapath nets
    logic [EXT_W-1:0]  ex, ey, ez;
    t_row              zmask;
    logic [EXT_W-1:0]  req_xe, req_ye, req_ze;
    logic              req_inside;
    logic [EXT_W:0]    nbx_t, nbx_m, nby_t, nby_m;
    logic              nb_ok, row_in, gen_last, can_emit, out_load;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    t_row              ram_wdata, ram_rdata, merged, lane_row, next_row;
    t_lane_ctl         lane_ctl;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x      <= SIZE_RST;
            r_size_y      <= SIZE_RST;
            r_size_z      <= SIZE_RST;
            r_birth_low   <= BIRTH_LOW_RST;
            r_birth_high  <= BIRTH_HIGH_RST;
            r_survive_low <= SURVIVE_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X:      r_size_x      <= i_cfg_data;
                CFG_SIZE_Y:      r_size_y      <= i_cfg_data;
                CFG_SIZE_Z:      r_size_z      <= i_cfg_data;
                CFG_BIRTH_LOW:   r_birth_low   <= i_cfg_data[RULE_W-1:0];
                CFG_BIRTH_HIGH:  r_birth_high  <= i_cfg_data[RULE_W-1:0];
                CFG_SURVIVE_LOW: r_survive_low <= i_cfg_data[RULE_W-1:0];
                default: ;
            endcase
        end
    end

    // used extents and the z lanes inside them
    assign ex = clamp_ext(r_size_x, MAX_X);
    assign ey = clamp_ext(r_size_y, MAX_Y);
    assign ez = clamp_ext(r_size_z, MAX_Z);

    always_comb begin
        for (int i = 0; i < MAX_Z; i++) begin
            zmask[i] = (EXT_W'(i) < ez);
        end
    end

    // single-cell request decode
    assign req_xe     = EXT_W'(i_cell_x);
    assign req_ye     = EXT_W'(i_cell_y);
    assign req_ze     = EXT_W'(i_cell_z);
    assign req_inside = (req_xe < ex) && (req_ye < ey) && (req_ze < ez);

    // neighbor row of the current walk position, offsets stand for -1..+1
    assign nbx_t  = {1'b0, EXT_W'(r_gx)} + (EXT_W + 1)'(r_dx);
    assign nby_t  = {1'b0, EXT_W'(r_gy)} + (EXT_W + 1)'(r_dy);
    assign nbx_m  = nbx_t - 1'b1;
    assign nby_m  = nby_t - 1'b1;
    assign nb_ok  = (nbx_t != '0) && (nbx_m < {1'b0, ex})
                 && (nby_t != '0) && (nby_m < {1'b0, ey});
    assign row_in   = (EXT_W'(r_gx) < ex) && (EXT_W'(r_gy) < ey);
    assign gen_last = (r_gx == X_W'(MAX_X - 1)) && (r_gy == Y_W'(MAX_Y - 1));

    // write item: replace one bit of the fetched row
    always_comb begin
        merged       = ram_rdata;
        merged[r_az] = r_aval;
    end

    assign lane_row = r_pend_use ? (ram_rdata & zmask) : '0;
    assign can_emit = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // sequencer: next state, RAM port control, lane control
    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_clr_cnt  = r_clr_cnt;
        n_gx       = r_gx;
        n_gy       = r_gy;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_pend_vld = 1'b0;
        n_pend_use = r_pend_use;
        n_pend_ctr = r_pend_ctr;
        n_req      = r_req;
        n_ax       = r_ax;
        n_ay       = r_ay;
        n_az       = r_az;
        n_aval     = r_aval;
        n_res_rd   = r_res_rd;
        n_res_st   = r_res_st;
        ram_we     = 1'b0;
        ram_waddr  = {1'b0, r_clr_cnt};
        ram_wdata  = '0;
        ram_raddr  = {r_sel, req_xe[X_W-1:0], req_ye[Y_W-1:0]};
        lane_ctl.clr    = 1'b0;
        lane_ctl.acc    = r_pend_vld;
        lane_ctl.center = r_pend_ctr;
        out_load   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_req_type;
                    n_ax     = req_xe[X_W-1:0];
                    n_ay     = req_ye[Y_W-1:0];
                    n_az     = req_ze[Z_W-1:0];
                    n_aval   = i_cell_value;
                    n_res_rd = 1'b0;
                    n_res_st = 1'b0;
                    unique case (i_req_type) inside
                        REQ_WRITE, REQ_READ: begin
                            if (req_inside) begin
                                n_state = S_ACC_WAIT;
                            end else begin
                                n_res_st = 1'b1;
                                n_state  = S_RESP;
                            end
                        end
                        REQ_STEP: begin
                            n_gx         = '0;
                            n_gy         = '0;
                            n_dx         = '0;
                            n_dy         = '0;
                            lane_ctl.clr = 1'b1;
                            n_state      = S_GEN_RD;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_ACC_WAIT: begin
                if (r_req == REQ_WRITE) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_sel, r_ax, r_ay};
                    ram_wdata = merged;
                end else begin
                    n_res_rd = ram_rdata[r_az];
                end
                n_state = S_RESP;
            end
            S_GEN_RD: begin
                ram_raddr  = {r_sel, nbx_m[X_W-1:0], nby_m[Y_W-1:0]};
                n_pend_vld = 1'b1;
                n_pend_use = nb_ok;
                n_pend_ctr = (r_dx == OFS_MID) && (r_dy == OFS_MID);
                if (r_dy == OFS_LAST) begin
                    n_dy = '0;
                    n_dx = r_dx + 1'b1;
                    if (r_dx == OFS_LAST) begin
                        n_state = S_GEN_FIN;
                    end
                end else begin
                    n_dy = r_dy + 1'b1;
                end
            end
            S_GEN_FIN: begin
                n_state = S_GEN_WR;
            end
            S_GEN_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = {~r_sel, r_gx, r_gy};
                ram_wdata    = next_row & zmask & {MAX_Z{row_in}};
                lane_ctl.clr = 1'b1;
                n_dx         = '0;
                n_dy         = '0;
                if (gen_last) begin
                    n_sel   = ~r_sel;
                    n_state = S_RESP;
                end else begin
                    n_state = S_GEN_RD;
                    if (r_gy == Y_W'(MAX_Y - 1)) begin
                        n_gy = '0;
                        n_gx = r_gx + 1'b1;
                    end else begin
                        n_gy = r_gy + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (can_emit) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_sel      <= 1'b0;
            r_clr_cnt  <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_clr_cnt  <= n_clr_cnt;
            r_pend_vld <= n_pend_vld;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_gx       <= n_gx;
        r_gy       <= n_gy;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_pend_use <= n_pend_use;
        r_pend_ctr <= n_pend_ctr;
        r_req      <= n_req;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_az       <= n_az;
        r_aval     <= n_aval;
        r_res_rd   <= n_res_rd;
        r_res_st   <= n_res_st;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rd <= r_res_rd;
            r_out_st <= r_res_st;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_read_value = r_out_rd;
    assign o_status     = r_out_st;

    // grid storage, both banks
    ca3d_ram #(
        .WIDTH (MAX_Z),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // neighbor counting and rule lanes
    ca3d_lane_unit u_lanes (
        .i_clk         (i_clk),
        .i_ctl         (lane_ctl),
        .i_row         (lane_row),
        .i_birth_low   (r_birth_low),
        .i_birth_high  (r_birth_high),
        .i_survive_low (r_survive_low),
        .o_next_row    (next_row)
    );

endmodule

`default_nettype wire

>>> design/ca3d_ram.sv
`default_nettype none

module ca3d_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/ca3d_lane_unit.sv
`default_nettype none

module ca3d_lane_unit import ca3d_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_lane_ctl         i_ctl,
    input  wire t_row              i_row,
    input  wire logic [RULE_W-1:0] i_birth_low,
    input  wire logic [RULE_W-1:0] i_birth_high,
    input  wire logic [RULE_W-1:0] i_survive_low,
    output t_row                   o_next_row
);

    logic [CNT_W-1:0] r_acc [MAX_Z];
    t_row             r_self;
    logic [1:0]       add [MAX_Z];

    // per-lane contribution of one fetched row: z-1, z (not on the center row), z+1
    always_comb begin
        for (int z = 0; z < MAX_Z; z++) begin
            logic lo;
            logic mid;
            logic hi;
            lo  = (z > 0) ? i_row[(z > 0) ? z - 1 : 0] : 1'b0;
            hi  = (z < MAX_Z - 1) ? i_row[(z < MAX_Z - 1) ? z + 1 : z] : 1'b0;
            mid = i_ctl.center ? 1'b0 : i_row[z];
            add[z] = {1'b0, lo} + {1'b0, mid} + {1'b0, hi};
        end
    end

    // neighbor count accumulators, one per lane
    always_ff @(posedge i_clk) begin
        for (int z = 0; z < MAX_Z; z++) begin
            if (i_ctl.clr) begin
                r_acc[z] <= '0;
            end else if (i_ctl.acc) begin
                r_acc[z] <= r_acc[z] + CNT_W'(add[z]);
            end
        end
        if (i_ctl.acc && i_ctl.center) begin
            r_self <= i_row;
        end
    end

    // birth / keep / die rule per lane
    always_comb begin
        for (int z = 0; z < MAX_Z; z++) begin
            logic born;
            logic keep;
            born = (r_acc[z] >= i_birth_low) && (r_acc[z] <= i_birth_high);
            keep = (r_acc[z] >= i_survive_low) && (r_acc[z] < i_birth_low);
            o_next_row[z] = born || (keep && r_self[z]);
        end
    end

endmodule

`default_nettype wire

>>> design/ca3d_chk.sv
`default_nettype none

`include "assert_macros.svh"

module ca3d_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_read_value,
    input wire logic o_status
);

    // a stalled result holds
    `CA3D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_read_value) && $stable(o_status), "result changed while stalled")

    // clearing pass after reset keeps the request side closed
    `CA3D_ASSERT_NEXT_ALWAYS(a_clear_blocks, i_clk, !i_rst_n, !o_in_ready, "item taken during clearing pass")

    // one item at a time
    `CA3D_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "item taken while busy")

    // a live read never carries an error status
    `CA3D_ASSERT_NOW(a_read_ok, i_clk, i_rst_n, o_out_valid && o_read_value, !o_status, "read value with error status")

endmodule

bind cellular_automaton_3d_step_top ca3d_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

`default_nettype wire
